/* rtl/tzc_pkg.sv */
// tzc_pkg: shared types, constants and functions of the TZ string checker.
// Holds the byte classifier used by the front end and the parse step used by the back end.
// No dependencies.
package tzc_pkg;

    localparam int CHAR_W = 8;
    localparam int REG_W  = 8;
    localparam int NUM_W  = 10;
    localparam int CNT_W  = 8;

    // default queue depth between front and back (range 2 and up)
    localparam int QUEUE_DEPTH_DEF = 2;

    // number of chained parse steps evaluated for one byte
    localparam int STEP_CHAIN = 7;

    // configuration register indexes
    localparam logic [0:0] REG_MIN_NAME_LEN   = 1'b0;
    localparam logic [0:0] REG_NAME_LEN_LIMIT = 1'b1;

    localparam logic [REG_W-1:0] MIN_NAME_LEN_RST   = 8'd3;
    localparam logic [REG_W-1:0] NAME_LEN_LIMIT_RST = 8'd16;

    // limits
    localparam logic [NUM_W-1:0] HOUR_MAX   = 10'd23;
    localparam logic [NUM_W-1:0] MINSEC_MAX = 10'd60;
    localparam logic [NUM_W-1:0] MONTH_MAX  = 10'd12;
    localparam logic [NUM_W-1:0] YDAY_MAX   = 10'd365;
    localparam logic [3:0]       WDAY_MAX   = 4'd6;
    localparam logic [3:0]       WEEK_MAX   = 4'd5;

    // characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_UP_J  = 8'h4A;

    typedef enum logic [3:0] {
        PH_START,
        PH_COLON_ALL,
        PH_STD_NAME,
        PH_DST_BEGIN,
        PH_DST_NAME,
        PH_AFTER_DST,
        PH_COMMA1,
        PH_COMMA2,
        PH_AFTER_D1,
        PH_AFTER_D2,
        PH_END,
        PH_DONE_OK,
        PH_OFFSET,
        PH_DATE
    } phase_t;

    // offset contexts
    localparam logic [1:0] CTX_STD   = 2'd0;
    localparam logic [1:0] CTX_DST   = 2'd1;
    localparam logic [1:0] CTX_RULE1 = 2'd2;
    localparam logic [1:0] CTX_RULE2 = 2'd3;

    // which rule date
    localparam logic [1:0] DATE_FIRST  = 2'd0;
    localparam logic [1:0] DATE_SECOND = 2'd1;

    // offset sub steps
    localparam logic [2:0] OFF_SIGN    = 3'd0;
    localparam logic [2:0] OFF_H1      = 3'd1;
    localparam logic [2:0] OFF_H2      = 3'd2;
    localparam logic [2:0] OFF_M1      = 3'd3;
    localparam logic [2:0] OFF_M2      = 3'd4;
    localparam logic [2:0] OFF_AFTER_M = 3'd5;
    localparam logic [2:0] OFF_S1      = 3'd6;
    localparam logic [2:0] OFF_S2      = 3'd7;

    // date sub steps
    localparam logic [2:0] DATE_KIND = 3'd0;
    localparam logic [2:0] DATE_MON1 = 3'd1;
    localparam logic [2:0] DATE_MON2 = 3'd2;
    localparam logic [2:0] DATE_WEEK = 3'd3;
    localparam logic [2:0] DATE_DAY1 = 3'd4;
    localparam logic [2:0] DATE_DAYN = 3'd5;
    localparam logic [2:0] DATE_DOT  = 3'd6;
    localparam logic [2:0] DATE_WDAY = 3'd7;

    // byte class, produced by the front end
    typedef struct packed {
        logic       is_zero;
        logic       is_dig;
        logic       is_name;
        logic       is_colon;
        logic       is_comma;
        logic       is_sign;
        logic       is_dot;
        logic       is_slash;
        logic       is_m;
        logic       is_j;
        logic       is_week;
        logic       is_wday;
        logic [3:0] digit;
    } cls_t;

    // parser state
    typedef struct packed {
        phase_t           phase;
        logic [1:0]       ctx;
        logic [2:0]       sub;
        logic [CNT_W-1:0] count;
        logic [NUM_W-1:0] num;
        logic             julian;
        logic             failed;
    } pst_t;

    typedef struct packed {
        pst_t st;
        logic again;
    } step_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam pst_t PST_RESET = '{
        phase:  PH_START,
        ctx:    CTX_STD,
        sub:    OFF_SIGN,
        count:  '0,
        num:    '0,
        julian: 1'b0,
        failed: 1'b0
    };

    function automatic cls_t classify(input logic [CHAR_W-1:0] c);
        cls_t r;
        r.is_zero  = (c == CH_NUL);
        r.is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.is_name  = !r.is_zero && !r.is_dig && (c != CH_COMMA) && (c != CH_MINUS)
                     && (c != CH_PLUS);
        r.is_colon = (c == CH_COLON);
        r.is_comma = (c == CH_COMMA);
        r.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        r.is_dot   = (c == CH_DOT);
        r.is_slash = (c == CH_SLASH);
        r.is_m     = (c == CH_UP_M);
        r.is_j     = (c == CH_UP_J);
        r.is_week  = (c >= CH_ONE) && (c <= (CH_ZERO + {4'h0, WEEK_MAX}));
        r.is_wday  = (c >= CH_ZERO) && (c <= (CH_ZERO + {4'h0, WDAY_MAX}));
        r.digit    = r.is_dig ? c[3:0] : 4'h0;
        return r;
    endfunction

    function automatic phase_t offset_done(input logic [1:0] ctx);
        phase_t p;
        case (ctx)
            CTX_STD:   p = PH_DST_BEGIN;
            CTX_DST:   p = PH_COMMA1;
            CTX_RULE1: p = PH_COMMA2;
            default:   p = PH_END;
        endcase
        return p;
    endfunction

    // One parse step. again set means the same byte must be handled once more.
    // acc is num * 10 + digit of the state held at the start of the byte.
    function automatic step_t parse_step(
        input pst_t             s,
        input cls_t             c,
        input logic [NUM_W-1:0] acc,
        input logic [REG_W-1:0] min_len,
        input logic [REG_W-1:0] len_lim
    );
        step_t  r;
        phase_t after_date;
        r.st       = s;
        r.again    = 1'b0;
        after_date = s.ctx[0] ? PH_AFTER_D2 : PH_AFTER_D1;
        case (s.phase)
            PH_START: begin
                if (c.is_colon) begin
                    r.st.phase = PH_COLON_ALL;
                end else begin
                    r.st.count = '0;
                    r.st.phase = PH_STD_NAME;
                    r.again    = 1'b1;
                end
            end
            PH_COLON_ALL: begin
                if (c.is_zero) r.st.phase = PH_DONE_OK;
            end
            PH_STD_NAME, PH_DST_NAME: begin
                if (c.is_name) begin
                    if (({1'b0, s.count} + 9'd1) >= {1'b0, len_lim}) r.st.failed = 1'b1;
                    else r.st.count = s.count + 8'd1;
                end else if (s.count < min_len) begin
                    r.st.failed = 1'b1;
                end else begin
                    if (s.phase == PH_STD_NAME) begin
                        r.st.phase = PH_OFFSET;
                        r.st.ctx   = CTX_STD;
                        r.st.sub   = OFF_SIGN;
                    end else begin
                        r.st.phase = PH_AFTER_DST;
                    end
                    r.again = 1'b1;
                end
            end
            PH_DST_BEGIN: begin
                if (c.is_zero) begin
                    r.st.phase = PH_DONE_OK;
                end else if (c.is_colon) begin
                    r.st.failed = 1'b1;
                end else begin
                    r.st.count = '0;
                    r.st.phase = PH_DST_NAME;
                    r.again    = 1'b1;
                end
            end
            PH_AFTER_DST: begin
                if (c.is_zero) begin
                    r.st.phase = PH_DONE_OK;
                end else begin
                    if (c.is_comma) begin
                        r.st.phase = PH_COMMA1;
                    end else begin
                        r.st.phase = PH_OFFSET;
                        r.st.ctx   = CTX_DST;
                        r.st.sub   = OFF_SIGN;
                    end
                    r.again = 1'b1;
                end
            end
            PH_COMMA1: begin
                if (c.is_zero) begin
                    r.st.phase = PH_DONE_OK;
                end else if (c.is_comma) begin
                    r.st.phase = PH_DATE;
                    r.st.ctx   = DATE_FIRST;
                    r.st.sub   = DATE_KIND;
                end else begin
                    r.st.failed = 1'b1;
                end
            end
            PH_COMMA2: begin
                if (c.is_comma) begin
                    r.st.phase = PH_DATE;
                    r.st.ctx   = DATE_SECOND;
                    r.st.sub   = DATE_KIND;
                end else begin
                    r.st.failed = 1'b1;
                end
            end
            PH_AFTER_D1, PH_AFTER_D2: begin
                if (c.is_slash) begin
                    r.st.phase = PH_OFFSET;
                    r.st.ctx   = (s.phase == PH_AFTER_D1) ? CTX_RULE1 : CTX_RULE2;
                    r.st.sub   = OFF_SIGN;
                end else begin
                    r.st.phase = (s.phase == PH_AFTER_D1) ? PH_COMMA2 : PH_END;
                    r.again    = 1'b1;
                end
            end
            PH_END: begin
                if (c.is_zero) r.st.phase = PH_DONE_OK;
                else r.st.failed = 1'b1;
            end
            PH_OFFSET: begin
                case (s.sub)
                    OFF_SIGN: begin
                        r.st.sub = OFF_H1;
                        // signs only in std and dst offsets
                        r.again  = !(!s.ctx[1] && c.is_sign);
                    end
                    OFF_H1, OFF_M1, OFF_S1: begin
                        if (!c.is_dig) begin
                            r.st.failed = 1'b1;
                        end else begin
                            r.st.num   = {6'd0, c.digit};
                            r.st.count = 8'd1;
                            r.st.sub   = s.sub + 3'd1;
                        end
                    end
                    OFF_H2: begin
                        if (c.is_dig) begin
                            if (s.count >= 8'd2) begin
                                r.st.failed = 1'b1;
                            end else begin
                                r.st.num   = acc;
                                r.st.count = s.count + 8'd1;
                            end
                        end else if (s.num > HOUR_MAX) begin
                            r.st.failed = 1'b1;
                        end else if (c.is_colon) begin
                            r.st.sub = OFF_M1;
                        end else begin
                            r.st.phase = offset_done(s.ctx);
                            r.again    = 1'b1;
                        end
                    end
                    OFF_M2, OFF_S2: begin
                        if (!c.is_dig) begin
                            r.st.failed = 1'b1;
                        end else begin
                            r.st.num   = acc;
                            r.st.count = s.count + 8'd1;
                            if (acc > MINSEC_MAX) r.st.failed = 1'b1;
                            else if (s.sub == OFF_M2) r.st.sub = OFF_AFTER_M;
                            else r.st.phase = offset_done(s.ctx);
                        end
                    end
                    default: begin
                        // after minutes
                        if (c.is_colon) begin
                            r.st.sub = OFF_S1;
                        end else begin
                            r.st.phase = offset_done(s.ctx);
                            r.again    = 1'b1;
                        end
                    end
                endcase
            end
            PH_DATE: begin
                case (s.sub)
                    DATE_KIND: begin
                        if (c.is_m) begin
                            r.st.julian = 1'b0;
                            r.st.sub    = DATE_MON1;
                        end else if (c.is_j) begin
                            r.st.julian = 1'b1;
                            r.st.sub    = DATE_DAY1;
                        end else if (c.is_dig) begin
                            r.st.julian = 1'b0;
                            r.st.num    = {6'd0, c.digit};
                            r.st.count  = 8'd1;
                            r.st.sub    = DATE_DAYN;
                        end else begin
                            r.st.failed = 1'b1;
                        end
                    end
                    DATE_MON1, DATE_DAY1: begin
                        if (!c.is_dig) begin
                            r.st.failed = 1'b1;
                        end else begin
                            r.st.num   = {6'd0, c.digit};
                            r.st.count = 8'd1;
                            r.st.sub   = s.sub + 3'd1;
                        end
                    end
                    DATE_MON2: begin
                        if (c.is_dig) begin
                            if (s.count >= 8'd2) begin
                                r.st.failed = 1'b1;
                            end else begin
                                r.st.num   = acc;
                                r.st.count = s.count + 8'd1;
                            end
                        end else if (c.is_dot && (s.num >= 10'd1) && (s.num <= MONTH_MAX)) begin
                            r.st.sub = DATE_WEEK;
                        end else begin
                            r.st.failed = 1'b1;
                        end
                    end
                    DATE_WEEK: begin
                        if (c.is_week) r.st.sub = DATE_DOT;
                        else r.st.failed = 1'b1;
                    end
                    DATE_DOT: begin
                        if (c.is_dot) r.st.sub = DATE_WDAY;
                        else r.st.failed = 1'b1;
                    end
                    DATE_WDAY: begin
                        if (c.is_wday) r.st.phase = after_date;
                        else r.st.failed = 1'b1;
                    end
                    default: begin
                        // plain or Julian day number
                        if (c.is_dig) begin
                            if (s.count >= 8'd3) begin
                                r.st.failed = 1'b1;
                            end else begin
                                r.st.num   = acc;
                                r.st.count = s.count + 8'd1;
                            end
                        end else if ((s.num > YDAY_MAX) || (s.julian && (s.num == '0))) begin
                            r.st.failed = 1'b1;
                        end else begin
                            r.st.phase = after_date;
                            r.again    = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                r.st.failed = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/tz_string_syntax_checker.sv */
// tz_string_syntax_checker: top level of the POSIX TZ string syntax checker.
// Depends on tzc_pkg, tzc_front, tzc_queue and tzc_back.
//
// Usage:
//   s_ channel: one string byte per beat in s_tdata; a zero byte ends a string.
//   m_ channel: one beat per string, sent for its zero byte; m_tdata[0] is 1 when
//   the string is a valid TZ string, 0 when rejected. Other bytes give no beat.
//   Config port: cfg_we writes cfg_wdata to register cfg_addr (0: min_name_len,
//   1: name_len_limit) at the clock edge; write only while no string is in flight.
// Throughput: one byte per cycle while s_tready is high. The front end classifies each byte into a short
//   queue; the back end resolves each byte through a combinational chain of parse steps.
// Result path: a zero byte that is taken is first written to the queue; once popped, its
//   result is written to the output register, which then drives the result beat.
// Reset (aresetn low, synchronous): parser restarts at the std name, queue empties,
//   registers return to 3 and 16, no result pending.
// Stall: while a result waits on m_tready, bytes of the next string keep flowing;
//   only the next zero byte waits in the queue, and s_tready drops once it fills.
module tz_string_syntax_checker #(
    parameter int QUEUE_DEPTH = tzc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_addr,
    input  logic [tzc_pkg::REG_W-1:0]   cfg_wdata,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] char_in
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [0] tz_valid, [7:1] zero
);

    logic [tzc_pkg::REG_W-1:0] min_len_reg, min_len_next;
    logic [tzc_pkg::REG_W-1:0] len_lim_reg, len_lim_next;

    tzc_pkg::q_stat_t q_stat;
    tzc_pkg::cls_t    push_cls;
    tzc_pkg::cls_t    head_cls;
    logic             q_push;
    logic             q_pop;
    logic             tz_valid;

    // config registers; the user must see that they are written only between strings; this block does not enforce it
    always_comb begin
        min_len_next = min_len_reg;
        len_lim_next = len_lim_reg;
        if (cfg_we) begin
            case (cfg_addr)
                tzc_pkg::REG_MIN_NAME_LEN:   min_len_next = cfg_wdata;
                tzc_pkg::REG_NAME_LEN_LIMIT: len_lim_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= tzc_pkg::MIN_NAME_LEN_RST;
            len_lim_reg <= tzc_pkg::NAME_LEN_LIMIT_RST;
        end else begin
            min_len_reg <= min_len_next;
            len_lim_reg <= len_lim_next;
        end
    end

    // front: handshake and byte classification
    tzc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cls    (push_cls)
    );

    // queue decoupling front from parser
    tzc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cls (push_cls),
        .pop      (q_pop),
        .head_cls (head_cls),
        .q_stat   (q_stat)
    );

    // back: parser and result register
    tzc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .head_cls       (head_cls),
        .q_pop          (q_pop),
        .min_name_len   (min_len_reg),
        .name_len_limit (len_lim_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tz_valid     (tz_valid)
    );

    assign m_tdata = {7'd0, tz_valid};

endmodule

/* rtl/tzc_front.sv */
// tzc_front: input side of the TZ checker; takes beats and classifies each byte.
// Depends on tzc_pkg.
module tzc_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tzc_pkg::CHAR_W-1:0]   s_tdata,
    input  tzc_pkg::q_stat_t             q_stat,
    output logic                         q_push,
    output tzc_pkg::cls_t                q_cls
);

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;
    assign q_cls    = tzc_pkg::classify(s_tdata);

endmodule

/* rtl/tzc_queue.sv */
// tzc_queue: short queue of classified bytes between front and back.
// Depends on tzc_pkg.
module tzc_queue #(
    parameter int DEPTH = tzc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tzc_pkg::cls_t    push_cls,
    input  logic             pop,
    output tzc_pkg::cls_t    head_cls,
    output tzc_pkg::q_stat_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tzc_pkg::cls_t      mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) cnt_next = cnt_reg + CNT_W'(1);
        else if (!push && pop) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cls;
        end
    end

    assign head_cls     = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_cnt_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

/* rtl/tzc_back.sv */
// tzc_back: parser of the TZ checker plus the result output register.
// Depends on tzc_pkg.
module tzc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tzc_pkg::q_stat_t            q_stat,
    input  tzc_pkg::cls_t               head_cls,
    output logic                        q_pop,
    input  logic [tzc_pkg::REG_W-1:0]   min_name_len,
    input  logic [tzc_pkg::REG_W-1:0]   name_len_limit,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_tz_valid
);

    tzc_pkg::pst_t                  st_reg, st_next, st_after;
    logic [tzc_pkg::NUM_W+3:0]      prod;
    logic [tzc_pkg::NUM_W-1:0]      acc;
    logic                           res_ok;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_data_reg, m_data_next;

    // num * 10 + digit, shared by every step of this byte
    assign prod = {1'b0, st_reg.num, 3'b000} + {3'b000, st_reg.num, 1'b0};
    assign acc  = prod[tzc_pkg::NUM_W-1:0] + {6'd0, head_cls.digit};

    // next state: chained steps over the same byte
    always_comb begin : next_state_logic
        tzc_pkg::step_t stp;
        stp.st    = st_reg;
        stp.again = 1'b1;
        for (int i = 0; i < tzc_pkg::STEP_CHAIN; i++) begin
            if (stp.again && !stp.st.failed) begin
                stp = tzc_pkg::parse_step(stp.st, head_cls, acc, min_name_len, name_len_limit);
            end
        end
        if (stp.again && !stp.st.failed) stp.st.failed = 1'b1;
        st_after = stp.st;

        st_next = st_reg;
        if (q_pop) begin
            st_next = head_cls.is_zero ? tzc_pkg::PST_RESET : st_after;
        end
    end

    // outputs: pop control and result register
    always_comb begin : output_logic
        res_ok       = !st_after.failed && (st_after.phase == tzc_pkg::PH_DONE_OK);
        q_pop        = !q_stat.empty && (!head_cls.is_zero || !m_valid_reg || m_tready);
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (q_pop && head_cls.is_zero) begin
            m_valid_next = 1'b1;
            m_data_next  = res_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= tzc_pkg::PST_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tz_valid = m_data_reg;

    a_zero_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && head_cls.is_zero) |=> m_valid_reg)
        else $error("zero byte popped without result");

    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && head_cls.is_zero) |=> (st_reg.phase == tzc_pkg::PH_START && !st_reg.failed))
        else $error("parser not restarted after zero byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && head_cls.is_zero && m_valid_reg && !m_tready))
        else $error("pending result overwritten");

endmodule
